FILE: sv/rsm_pkg.sv
package rsm_pkg;

  localparam int TRIG_STEPS = 24;
  localparam int DIV_BITS   = 33;

  localparam logic REQ_ROT  = 1'b0;
  localparam logic REQ_SKEW = 1'b1;

  localparam logic [16:0] DEG_90  = 17'd23040;
  localparam logic [16:0] DEG_180 = 17'd46080;
  localparam logic [16:0] DEG_270 = 17'd69120;

  localparam logic signed [31:0] SCL_HALF    = 32'sd754974720;
  localparam logic signed [31:0] SCL_QUARTER = 32'sd377487360;
  localparam logic signed [31:0] SCL_FULL    = 32'sd1509949440;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic [26:0]        RECIP45     = 27'd95443718;
  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;

  typedef enum logic [1:0] {
    TAN_DIV,
    TAN_ZERO,
    TAN_POS,
    TAN_NEG
  } tan_kind_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
  } side_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [31:0] t;
    logic               neg;
    logic [16:0]        r;
  } cl_t;

  typedef struct packed {
    side_t              side;
    logic signed [17:0] c16;
    logic signed [17:0] s16;
  } dside_t;

  typedef struct packed {
    logic [47:0] n;
    logic [31:0] d;
    logic        neg;
    tan_kind_t   kind;
  } dl_t;

  typedef struct packed {
    logic [32:0] rem;
    logic [32:0] q;
    logic        ovf;
    logic [47:0] n;
    logic [31:0] d;
    logic        neg;
    tan_kind_t   kind;
  } dw_t;

  function automatic logic signed [31:0] atan_deg22(input logic [4:0] i);
    logic signed [31:0] v;
    case (i)
      5'd0:    v = 32'sd188743680;
      5'd1:    v = 32'sd111421900;
      5'd2:    v = 32'sd58872272;
      5'd3:    v = 32'sd29884485;
      5'd4:    v = 32'sd15000234;
      5'd5:    v = 32'sd7507429;
      5'd6:    v = 32'sd3754631;
      5'd7:    v = 32'sd1877430;
      5'd8:    v = 32'sd938729;
      5'd9:    v = 32'sd469366;
      5'd10:   v = 32'sd234683;
      5'd11:   v = 32'sd117342;
      5'd12:   v = 32'sd58671;
      5'd13:   v = 32'sd29335;
      5'd14:   v = 32'sd14668;
      5'd15:   v = 32'sd7334;
      5'd16:   v = 32'sd3667;
      5'd17:   v = 32'sd1833;
      5'd18:   v = 32'sd917;
      5'd19:   v = 32'sd458;
      5'd20:   v = 32'sd229;
      5'd21:   v = 32'sd115;
      5'd22:   v = 32'sd57;
      5'd23:   v = 32'sd29;
      5'd24:   v = 32'sd14;
      5'd25:   v = 32'sd7;
      5'd26:   v = 32'sd4;
      5'd27:   v = 32'sd2;
      5'd28:   v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/rsm_reduce.sv
module rsm_reduce (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  rsm_pkg::side_t       side_i,
  input  logic signed [31:0]   ax_i,
  input  logic signed [31:0]   ay_i,
  output logic                 vld_o,
  output rsm_pkg::side_t       side_o,
  output logic [16:0]          rx_o,
  output logic [16:0]          ry_o
);

  logic [1:0][31:0] a;
  logic [1:0][20:0] u_nxt;
  logic [1:0][15:0] q_nxt;
  logic [1:0][5:0]  h_nxt;

  logic             v1_r;
  rsm_pkg::side_t   side1_r;
  logic [1:0][20:0] u1_r;
  logic [1:0][15:0] q1_r;
  logic [1:0][10:0] lo1_r;

  logic             v2_r;
  rsm_pkg::side_t   side2_r;
  logic [1:0][5:0]  h2_r;
  logic [1:0][10:0] lo2_r;

  assign a[0] = ax_i;
  assign a[1] = ay_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [47:0] prod;
      u_nxt[l] = {~a[l][31], a[l][30:11]};
      prod     = 48'(u_nxt[l]) * 48'(rsm_pkg::RECIP45);
      q_nxt[l] = prod[47:32];
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [5:0] r0;
      r0 = 6'(u1_r[l] - 21'(21'(q1_r[l]) * 21'd45));
      if (r0 >= 6'd31) begin
        h_nxt[l] = r0 - 6'd31;
      end else begin
        h_nxt[l] = r0 + 6'd14;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r  <= side_i;
      u1_r     <= u_nxt;
      q1_r     <= q_nxt;
      lo1_r[0] <= a[0][10:0];
      lo1_r[1] <= a[1][10:0];
      side2_r  <= side1_r;
      h2_r     <= h_nxt;
      lo2_r    <= lo1_r;
    end
  end

  assign vld_o  = v2_r;
  assign side_o = side2_r;
  assign rx_o   = {h2_r[0], lo2_r[0]};
  assign ry_o   = {h2_r[1], lo2_r[1]};

endmodule

FILE: sv/rsm_cordic.sv
module rsm_cordic (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  vld_i,
  input  rsm_pkg::side_t        side_i,
  input  logic [16:0]           rx_i,
  input  logic [16:0]           ry_i,
  output logic                  vld_o,
  output rsm_pkg::side_t        side_o,
  output logic [1:0][33:0]      c_o,
  output logic [1:0][33:0]      s_o,
  output logic [1:0][16:0]      r_o
);

  rsm_pkg::cl_t [1:0] st_r   [rsm_pkg::TRIG_STEPS+1];
  logic               v_r    [rsm_pkg::TRIG_STEPS+1];
  rsm_pkg::side_t     side_r [rsm_pkg::TRIG_STEPS+1];

  rsm_pkg::cl_t [1:0] fold_nxt;
  logic [1:0][16:0]   rin;

  logic               vo_r;
  rsm_pkg::side_t     sideo_r;
  logic [1:0][33:0]   co_r;
  logic [1:0][33:0]   so_r;
  logic [1:0][16:0]   ro_r;

  assign rin[0] = rx_i;
  assign rin[1] = ry_i;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic signed [31:0] t0;
      logic signed [31:0] t1;
      t0 = signed'({1'b0, rin[l], 14'b0});
      t1 = t0;
      fold_nxt[l].neg = 1'b0;
      if (t0 > rsm_pkg::SCL_HALF) begin
        t1 = t0 - rsm_pkg::SCL_FULL;
      end
      if (t1 > rsm_pkg::SCL_QUARTER) begin
        t1 = t1 - rsm_pkg::SCL_HALF;
        fold_nxt[l].neg = 1'b1;
      end else if (t1 < -rsm_pkg::SCL_QUARTER) begin
        t1 = t1 + rsm_pkg::SCL_HALF;
        fold_nxt[l].neg = 1'b1;
      end
      fold_nxt[l].t = t1;
      fold_nxt[l].x = rsm_pkg::GAIN_Q30;
      fold_nxt[l].y = 34'sd0;
      fold_nxt[l].r = rin[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= fold_nxt;
      side_r[0] <= side_i;
    end
  end

  for (genvar i = 0; i < rsm_pkg::TRIG_STEPS; i++) begin : g_it
    rsm_pkg::cl_t [1:0] it_nxt;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [31:0] at;
        dx = $signed(st_r[i][l].y) >>> i;
        dy = $signed(st_r[i][l].x) >>> i;
        at = rsm_pkg::atan_deg22(5'(i));
        it_nxt[l] = st_r[i][l];
        if (!st_r[i][l].t[31]) begin
          it_nxt[l].x = $signed(st_r[i][l].x) - dx;
          it_nxt[l].y = $signed(st_r[i][l].y) + dy;
          it_nxt[l].t = $signed(st_r[i][l].t) - at;
        end else begin
          it_nxt[l].x = $signed(st_r[i][l].x) + dx;
          it_nxt[l].y = $signed(st_r[i][l].y) - dy;
          it_nxt[l].t = $signed(st_r[i][l].t) + at;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1]   <= it_nxt;
        side_r[i+1] <= side_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[rsm_pkg::TRIG_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sideo_r <= side_r[rsm_pkg::TRIG_STEPS];
      for (int l = 0; l < 2; l++) begin
        if (st_r[rsm_pkg::TRIG_STEPS][l].neg) begin
          co_r[l] <= -st_r[rsm_pkg::TRIG_STEPS][l].x;
          so_r[l] <= -st_r[rsm_pkg::TRIG_STEPS][l].y;
        end else begin
          co_r[l] <= st_r[rsm_pkg::TRIG_STEPS][l].x;
          so_r[l] <= st_r[rsm_pkg::TRIG_STEPS][l].y;
        end
        ro_r[l] <= st_r[rsm_pkg::TRIG_STEPS][l].r;
      end
    end
  end

  assign vld_o  = vo_r;
  assign side_o = sideo_r;
  assign c_o    = co_r;
  assign s_o    = so_r;
  assign r_o    = ro_r;

endmodule

FILE: sv/rsm_div.sv
module rsm_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   vld_i,
  input  rsm_pkg::dside_t        side_i,
  input  rsm_pkg::dl_t [1:0]     lane_i,
  output logic                   vld_o,
  output rsm_pkg::dside_t        side_o,
  output logic [1:0][31:0]       tan_o
);

  rsm_pkg::dw_t [1:0] st_r   [rsm_pkg::DIV_BITS+1];
  logic               v_r    [rsm_pkg::DIV_BITS+1];
  rsm_pkg::dside_t    side_r [rsm_pkg::DIV_BITS+1];

  rsm_pkg::dw_t [1:0] init_nxt;
  logic [1:0][31:0]   tan_nxt;

  logic               vo_r;
  rsm_pkg::dside_t    sideo_r;
  logic [1:0][31:0]   tano_r;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      init_nxt[l].rem  = {18'b0, lane_i[l].n[47:33]};
      init_nxt[l].q    = '0;
      init_nxt[l].ovf  = ({17'b0, lane_i[l].n} >= {lane_i[l].d, 33'b0});
      init_nxt[l].n    = lane_i[l].n;
      init_nxt[l].d    = lane_i[l].d;
      init_nxt[l].neg  = lane_i[l].neg;
      init_nxt[l].kind = lane_i[l].kind;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= init_nxt;
      side_r[0] <= side_i;
    end
  end

  for (genvar k = 0; k < rsm_pkg::DIV_BITS; k++) begin : g_bit
    localparam int J = rsm_pkg::DIV_BITS - 1 - k;
    rsm_pkg::dw_t [1:0] bit_nxt;

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        logic [32:0] rsh;
        logic        ge;
        rsh = {st_r[k][l].rem[31:0], st_r[k][l].n[J]};
        ge  = (rsh >= {1'b0, st_r[k][l].d});
        bit_nxt[l] = st_r[k][l];
        bit_nxt[l].rem  = ge ? (rsh - {1'b0, st_r[k][l].d}) : rsh;
        bit_nxt[l].q[J] = ge;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[k+1]   <= bit_nxt;
        side_r[k+1] <= side_r[k];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      rsm_pkg::dw_t w;
      logic [32:0]  nq;
      w  = st_r[rsm_pkg::DIV_BITS][l];
      nq = -w.q;
      case (w.kind)
        rsm_pkg::TAN_ZERO: tan_nxt[l] = 32'h0000_0000;
        rsm_pkg::TAN_POS:  tan_nxt[l] = 32'h7FFF_FFFF;
        rsm_pkg::TAN_NEG:  tan_nxt[l] = 32'h8000_0000;
        default: begin
          if (w.neg) begin
            tan_nxt[l] = (w.ovf || w.q > 33'h0_8000_0000) ? 32'h8000_0000 : nq[31:0];
          end else begin
            tan_nxt[l] = (w.ovf || w.q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w.q[31:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= v_r[rsm_pkg::DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sideo_r <= side_r[rsm_pkg::DIV_BITS];
      tano_r  <= tan_nxt;
    end
  end

  assign vld_o  = vo_r;
  assign side_o = sideo_r;
  assign tan_o  = tano_r;

endmodule

FILE: sv/rotate_skew_matrix_builder.sv
// Pipeline: from input transfer to result, a request passes through the 24-step
// CORDIC and the 33-bit restoring divider, one stage per step.
// Throughput: one request per cycle; the whole pipeline holds while a
// result waits on out_ready.
// Reset: rst_n (synchronous, active low) clears all stage valid bits;
// data registers are not reset.
module rotate_skew_matrix_builder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic signed [31:0] in_angle_x,
  input  logic signed [31:0] in_angle_y,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_m11,
  output logic signed [31:0] out_m12,
  output logic signed [31:0] out_m21,
  output logic signed [31:0] out_m22,
  output logic signed [31:0] out_offset_x,
  output logic signed [31:0] out_offset_y
);

  logic               en;
  rsm_pkg::side_t     side_in;

  logic               red_vld;
  rsm_pkg::side_t     red_side;
  logic [16:0]        red_rx;
  logic [16:0]        red_ry;

  logic               cor_vld;
  rsm_pkg::side_t     cor_side;
  logic [1:0][33:0]   cor_c;
  logic [1:0][33:0]   cor_s;
  logic [1:0][16:0]   cor_r;

  logic               vp_r;
  rsm_pkg::dside_t    dsp_r;
  rsm_pkg::dl_t [1:0] dlp_r;
  rsm_pkg::dside_t    ds_nxt;
  rsm_pkg::dl_t [1:0] dl_nxt;

  logic               div_vld;
  rsm_pkg::dside_t    div_side;
  logic [1:0][31:0]   div_tan;

  logic               vm_r;
  logic               rot_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [31:0] m11_r, m12_r, m21_r, m22_r;
  logic signed [63:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt;
  logic signed [31:0] m11_nxt, m12_nxt, m21_nxt, m22_nxt;

  logic               vo_r;
  logic signed [31:0] m11o_r, m12o_r, m21o_r, m22o_r, offx_r, offy_r;
  logic signed [31:0] offx_nxt, offy_nxt;

  assign en       = !vo_r || out_ready;
  assign in_ready = en;

  assign side_in.req_type = in_req_type;
  assign side_in.cx       = in_center_x;
  assign side_in.cy       = in_center_y;

  rsm_reduce u_reduce (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid && in_ready),
    .side_i (side_in),
    .ax_i   (in_angle_x),
    .ay_i   (in_angle_y),
    .vld_o  (red_vld),
    .side_o (red_side),
    .rx_o   (red_rx),
    .ry_o   (red_ry)
  );

  rsm_cordic u_cordic (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (red_vld),
    .side_i (red_side),
    .rx_i   (red_rx),
    .ry_i   (red_ry),
    .vld_o  (cor_vld),
    .side_o (cor_side),
    .c_o    (cor_c),
    .s_o    (cor_s),
    .r_o    (cor_r)
  );

  always_comb begin
    logic signed [33:0] cr;
    logic signed [33:0] sr;
    ds_nxt.side = cor_side;
    cr = ($signed(cor_c[0]) + 34'sd8192) >>> 14;
    sr = ($signed(cor_s[0]) + 34'sd8192) >>> 14;
    if (cor_r[0] == 17'd0) begin
      ds_nxt.c16 = 18'sd65536;
      ds_nxt.s16 = 18'sd0;
    end else if (cor_r[0] == rsm_pkg::DEG_90) begin
      ds_nxt.c16 = 18'sd0;
      ds_nxt.s16 = 18'sd65536;
    end else if (cor_r[0] == rsm_pkg::DEG_180) begin
      ds_nxt.c16 = -18'sd65536;
      ds_nxt.s16 = 18'sd0;
    end else if (cor_r[0] == rsm_pkg::DEG_270) begin
      ds_nxt.c16 = 18'sd0;
      ds_nxt.s16 = -18'sd65536;
    end else begin
      ds_nxt.c16 = cr[17:0];
      ds_nxt.s16 = sr[17:0];
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      logic [33:0] abs_s;
      logic [33:0] abs_c;
      abs_s = cor_s[l][33] ? -cor_s[l] : cor_s[l];
      abs_c = cor_c[l][33] ? -cor_c[l] : cor_c[l];
      dl_nxt[l].n   = {abs_s[31:0], 16'b0};
      dl_nxt[l].d   = abs_c[31:0];
      dl_nxt[l].neg = cor_s[l][33] ^ cor_c[l][33];
      if (cor_r[l] == 17'd0 || cor_r[l] == rsm_pkg::DEG_180) begin
        dl_nxt[l].kind = rsm_pkg::TAN_ZERO;
      end else if (cor_r[l] == rsm_pkg::DEG_90 || cor_r[l] == rsm_pkg::DEG_270) begin
        dl_nxt[l].kind = rsm_pkg::TAN_POS;
      end else if (cor_c[l] == 34'd0) begin
        dl_nxt[l].kind = cor_s[l][33] ? rsm_pkg::TAN_NEG : rsm_pkg::TAN_POS;
      end else begin
        dl_nxt[l].kind = rsm_pkg::TAN_DIV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
    end else if (en) begin
      vp_r <= cor_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsp_r <= ds_nxt;
      dlp_r <= dl_nxt;
    end
  end

  rsm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vp_r),
    .side_i (dsp_r),
    .lane_i (dlp_r),
    .vld_o  (div_vld),
    .side_o (div_side),
    .tan_o  (div_tan)
  );

  always_comb begin
    logic               rot;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] onec;
    logic signed [31:0] s32;
    logic signed [31:0] c32;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    rot  = (div_side.side.req_type == rsm_pkg::REQ_ROT);
    cx   = div_side.side.cx;
    cy   = div_side.side.cy;
    c32  = 32'(div_side.c16);
    s32  = 32'(div_side.s16);
    onec = rsm_pkg::ONE_Q16 - c32;
    tx   = $signed(div_tan[0]);
    ty   = $signed(div_tan[1]);
    p0_nxt = rot ? 64'(cx) * 64'(onec) : 64'(cy) * 64'(tx);
    p1_nxt = 64'(cy) * 64'(s32);
    p2_nxt = rot ? 64'(cy) * 64'(onec) : 64'(cx) * 64'(ty);
    p3_nxt = 64'(cx) * 64'(s32);
    if (rot) begin
      m11_nxt = c32;
      m12_nxt = s32;
      m21_nxt = -s32;
      m22_nxt = c32;
    end else begin
      m11_nxt = rsm_pkg::ONE_Q16;
      m12_nxt = ty;
      m21_nxt = tx;
      m22_nxt = rsm_pkg::ONE_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (en) begin
      vm_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= (div_side.side.req_type == rsm_pkg::REQ_ROT);
      p0_r  <= p0_nxt;
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      m11_r <= m11_nxt;
      m12_r <= m12_nxt;
      m21_r <= m21_nxt;
      m22_r <= m22_nxt;
    end
  end

  always_comb begin
    logic signed [65:0] sx;
    logic signed [65:0] sy;
    logic signed [65:0] hx;
    logic signed [65:0] hy;
    if (rot_r) begin
      sx = 66'(p0_r) + 66'(p1_r);
      sy = 66'(p2_r) - 66'(p3_r);
    end else begin
      sx = -66'(p0_r);
      sy = -66'(p2_r);
    end
    hx = (sx + 66'sd32768) >>> 16;
    hy = (sy + 66'sd32768) >>> 16;
    if (hx > 66'sd2147483647) begin
      offx_nxt = 32'sh7FFF_FFFF;
    end else if (hx < -66'sd2147483648) begin
      offx_nxt = 32'sh8000_0000;
    end else begin
      offx_nxt = hx[31:0];
    end
    if (hy > 66'sd2147483647) begin
      offy_nxt = 32'sh7FFF_FFFF;
    end else if (hy < -66'sd2147483648) begin
      offy_nxt = 32'sh8000_0000;
    end else begin
      offy_nxt = hy[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m11o_r <= m11_r;
      m12o_r <= m12_r;
      m21o_r <= m21_r;
      m22o_r <= m22_r;
      offx_r <= offx_nxt;
      offy_r <= offy_nxt;
    end
  end

  assign out_valid    = vo_r;
  assign out_m11      = m11o_r;
  assign out_m12      = m12o_r;
  assign out_m21      = m21o_r;
  assign out_m22      = m22o_r;
  assign out_offset_x = offx_r;
  assign out_offset_y = offy_r;

endmodule

FILE: sv/rsm_checker.sv
module rsm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_req_type,
  input logic signed [31:0] in_angle_x,
  input logic signed [31:0] in_angle_y,
  input logic signed [31:0] in_center_x,
  input logic signed [31:0] in_center_y,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_m11,
  input logic signed [31:0] out_m12,
  input logic signed [31:0] out_m21,
  input logic signed [31:0] out_m22,
  input logic signed [31:0] out_offset_x,
  input logic signed [31:0] out_offset_y
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_m11) && $stable(out_m12)
      && $stable(out_offset_x) && $stable(out_offset_y))
    else $error("stalled result changed");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline stalled");

  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_m11 == out_m22)
    else $error("diagonal mismatch");

  a_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_m11 == 32'sd65536) || (out_m21 == -out_m12))
    else $error("rotation off-diagonal mismatch");

endmodule

bind rotate_skew_matrix_builder rsm_checker u_rsm_checker (.*);
